// ----- sv/plq_pkg.sv -----
// ----------------------------------------------------------------------------
// plq_pkg: shared types and constants of the piecewise-linear integral core
// Transaction structs, knot memory entry layout, operation, status and
// configuration codes, and the 128-bit extension and saturation helpers.
// ----------------------------------------------------------------------------
package plq_pkg;

    localparam int FRAC_BITS = 16;

    typedef logic signed [127:0] wide_t;

    localparam wide_t INV3 = wide_t'(128'hAAAAAAAA_AAAAAAAA_AAAAAAAA_AAAAAAAB);

    localparam logic [1:0] OP_CLEAR = 2'd0;
    localparam logic [1:0] OP_LOAD  = 2'd1;
    localparam logic [1:0] OP_QUERY = 2'd2;

    localparam logic [2:0] ST_OK         = 3'd0;
    localparam logic [2:0] ST_NOT_INC    = 3'd1;
    localparam logic [2:0] ST_RANGE      = 3'd2;
    localparam logic [2:0] ST_BAD_INDEX  = 3'd3;
    localparam logic [2:0] ST_INDEX_ZERO = 3'd4;
    localparam logic [2:0] ST_FULL       = 3'd5;

    localparam logic [1:0] CFG_MODE         = 2'd0;
    localparam logic [1:0] CFG_TOP_WIDTH    = 2'd1;
    localparam logic [1:0] CFG_WIDTH_SLOPE  = 2'd2;
    localparam logic [1:0] CFG_SLICE_HEIGHT = 2'd3;

    typedef struct packed {
        logic [1:0]         op;
        logic signed [31:0] knot_x;
        logic signed [31:0] knot_sigma;
        logic signed [31:0] cut_x;
        logic [7:0]         cut_index;
        logic signed [31:0] cut_sigma;
    } in_item_t;

    typedef struct packed {
        logic [2:0]         status;
        logic signed [63:0] area;
        logic signed [63:0] moment;
    } out_item_t;

    typedef struct packed {
        logic signed [31:0] pos;
        logic signed [31:0] sig;
        logic signed [31:0] wid;
        logic signed [63:0] area;
        logic signed [63:0] moment;
    } entry_t;

    function automatic wide_t sx32(input logic signed [31:0] v);
        return wide_t'(v);
    endfunction

    function automatic wide_t sx64(input logic signed [63:0] v);
        return wide_t'(v);
    endfunction

    function automatic logic signed [63:0] sat64(input wide_t v);
        logic signed [63:0] lo;
        lo = v[63:0];
        if (sx64(lo) == v) return lo;
        return v[127] ? {1'b1, {63{1'b0}}} : {1'b0, {63{1'b1}}};
    endfunction

    function automatic logic signed [31:0] sat32(input wide_t v);
        logic signed [31:0] lo;
        lo = v[31:0];
        if (sx32(lo) == v) return lo;
        return v[127] ? {1'b1, {31{1'b0}}} : {1'b0, {31{1'b1}}};
    endfunction

    // remainder of a signed value by three, in 0..2; fold on powers of two
    // congruent to one, then add two for the sign weight
    function automatic logic [1:0] mod3(input wide_t v);
        logic [64:0] f64;
        logic [33:0] f32;
        logic [17:0] f16;
        logic [9:0]  f8;
        logic [5:0]  f4;
        logic [3:0]  f2;
        logic [1:0]  r;
        f64 = 65'(v[63:0]) + 65'(v[127:64]);
        f32 = 34'(f64[31:0]) + 34'(f64[63:32]) + 34'(f64[64]);
        f16 = 18'(f32[15:0]) + 18'(f32[31:16]) + 18'(f32[33:32]);
        f8  = 10'(f16[7:0]) + 10'(f16[15:8]) + 10'(f16[17:16]);
        f4  = 6'(f8[3:0]) + 6'(f8[7:4]) + 6'(f8[9:8]);
        f2  = 4'(f4[1:0]) + 4'(f4[3:2]) + 4'(f4[5:4]) + (v[127] ? 4'd2 : 4'd0);
        case (f2)
            4'd1, 4'd4, 4'd7, 4'd10: r = 2'd1;
            4'd2, 4'd5, 4'd8, 4'd11: r = 2'd2;
            default:                 r = 2'd0;
        endcase
        return r;
    endfunction

endpackage

// ----- sv/piecewise_linear_integral_query_core.sv -----
// ----------------------------------------------------------------------------
// piecewise_linear_integral_query_core: knot store with prefix integrals
// Loads knots with strictly increasing position, keeps prefix sums of area
// and first moment per knot, and answers partial-integral queries.
// ----------------------------------------------------------------------------
// One transaction at a time: start is taken while busy is low, and its result
// appears on result with done high for exactly one cycle; the receiver cannot
// hold it off. Clear and unknown operations answer in the cycle after start.
// Each multiply runs on the shared 16-step multiplier, a divide on the
// bit-serial divider, and every knot read passes through RD_WAIT on the
// registered-read knot memory. A rectangular load uses six multiplies, a
// trapezoid load seven, a rectangular query five, and a trapezoid query
// three multiplies and one divide (the longest).
// The moment's division by six is a shift, a remainder by three and a multiply
// by the inverse of three. There is no clearing pass after reset.
// Configuration writes are always accepted and must only be issued while busy
// is low.
module piecewise_linear_integral_query_core #(
    parameter int MAX_KNOTS = 256
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  plq_pkg::in_item_t   cmd,
    output logic                busy,
    output logic                done,
    output plq_pkg::out_item_t  result,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [1:0]          cfg_index,
    input  logic [31:0]         cfg_data
);
    import plq_pkg::*;

    localparam int AW = (MAX_KNOTS > 1) ? $clog2(MAX_KNOTS) : 1;
    localparam int CW = $clog2(MAX_KNOTS + 1);
    localparam int IW = (CW > 8) ? CW : 8;

    typedef enum logic [4:0] {
        IDLE, RD_WAIT, MUL_WAIT, DIV_WAIT,
        LD_PREV, LD_W, LD_W2, LD_T1, LD_T2,
        SEG_R, MOM0, MOM1, MOM2, MOM3, MOM_R, MOM_Q, MOM4,
        Q_FIRST, Q_LAST, Q_IDX, Q_PREV, Q_T1, Q_T2, Q_T3, Q_T4
    } state_t;

    state_t               state_reg;
    state_t               ret_reg;
    logic [CW-1:0]        count_reg;
    logic                 section_mode_reg;
    logic signed [31:0]   top_width_reg;
    logic signed [31:0]   width_slope_reg;
    logic [30:0]          slice_height_reg;

    logic [1:0]           op_reg;
    logic signed [31:0]   x_reg;
    logic signed [31:0]   s_reg;
    logic [7:0]           idx_reg;
    logic signed [31:0]   a_reg;
    logic signed [31:0]   sa_reg;
    logic signed [31:0]   wa_reg;
    logic signed [31:0]   wb_reg;
    logic signed [31:0]   b_reg;
    logic signed [31:0]   x0_reg;
    logic signed [31:0]   w_reg;
    logic signed [63:0]   ap_reg;
    logic signed [63:0]   mp_reg;
    logic signed [63:0]   area_reg;
    wide_t                prod_reg;
    wide_t                acc_reg;
    logic [1:0]           rem3_reg;

    logic                 done_reg;
    out_item_t            result_reg;

    logic                 wr_en_reg;
    logic [AW-1:0]        wr_addr_reg;
    entry_t               wr_data_reg;
    logic [AW-1:0]        rd_addr_reg;
    entry_t               rd_data;

    logic                 mul_go_reg;
    wide_t                mul_a_reg;
    wide_t                mul_b_reg;
    logic                 mul_done;
    wide_t                mul_p;

    logic                 div_go_reg;
    wide_t                div_n_reg;
    logic [31:0]          div_d_reg;
    logic                 div_done;
    wide_t                div_q;

    wide_t                xw;
    wide_t                sw;
    wide_t                aw_w;
    wide_t                saw;
    wide_t                waw;
    wide_t                wbw;
    wide_t                rect_seg;
    wide_t                trap_seg;
    logic signed [31:0]   w_new;
    logic signed [31:0]   bb_new;
    logic signed [63:0]   mom_new;
    logic [31:0]          den;
    logic [IW-1:0]        idx_ext;
    logic [IW-1:0]        cnt_ext;

    plq_mem #(
        .DEPTH (MAX_KNOTS),
        .AW    (AW)
    ) u_mem (
        .clk     (clk),
        .wr_en   (wr_en_reg),
        .wr_addr (wr_addr_reg),
        .wr_data (wr_data_reg),
        .rd_addr (rd_addr_reg),
        .rd_data (rd_data)
    );

    plq_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .go    (mul_go_reg),
        .a     (mul_a_reg),
        .b     (mul_b_reg),
        .done  (mul_done),
        .p     (mul_p)
    );

    plq_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .go    (div_go_reg),
        .n     (div_n_reg),
        .d     (div_d_reg),
        .done  (div_done),
        .q     (div_q)
    );

    always_comb
    begin
        xw       = sx32(x_reg);
        sw       = sx32(s_reg);
        aw_w     = sx32(a_reg);
        saw      = sx32(sa_reg);
        waw      = sx32(wa_reg);
        wbw      = sx32(wb_reg);
        rect_seg = prod_reg >>> 1;
        trap_seg = (prod_reg >>> FRAC_BITS) >>> 2;
        w_new    = sat32((prod_reg >>> FRAC_BITS) + sx32(top_width_reg));
        bb_new   = sat32(waw + prod_reg);
        mom_new  = sat64(sx64(mp_reg) + prod_reg);
        den      = 32'(b_reg) - 32'(a_reg);
        idx_ext  = IW'(idx_reg);
        cnt_ext  = IW'(count_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= IDLE;
            ret_reg          <= IDLE;
            count_reg        <= '0;
            section_mode_reg <= 1'b0;
            top_width_reg    <= '0;
            width_slope_reg  <= '0;
            slice_height_reg <= '0;
            op_reg           <= '0;
            x_reg            <= '0;
            s_reg            <= '0;
            idx_reg          <= '0;
            a_reg            <= '0;
            sa_reg           <= '0;
            wa_reg           <= '0;
            wb_reg           <= '0;
            b_reg            <= '0;
            x0_reg           <= '0;
            w_reg            <= '0;
            ap_reg           <= '0;
            mp_reg           <= '0;
            area_reg         <= '0;
            prod_reg         <= '0;
            acc_reg          <= '0;
            rem3_reg         <= '0;
            done_reg         <= 1'b0;
            result_reg       <= '0;
            wr_en_reg        <= 1'b0;
            wr_addr_reg      <= '0;
            wr_data_reg      <= '0;
            rd_addr_reg      <= '0;
            mul_go_reg       <= 1'b0;
            mul_a_reg        <= '0;
            mul_b_reg        <= '0;
            div_go_reg       <= 1'b0;
            div_n_reg        <= '0;
            div_d_reg        <= '0;
        end
        else
        begin
            done_reg   <= 1'b0;
            wr_en_reg  <= 1'b0;
            mul_go_reg <= 1'b0;
            div_go_reg <= 1'b0;

            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_MODE:         section_mode_reg <= cfg_data[0];
                    CFG_TOP_WIDTH:    top_width_reg    <= cfg_data;
                    CFG_WIDTH_SLOPE:  width_slope_reg  <= cfg_data;
                    CFG_SLICE_HEIGHT: slice_height_reg <= cfg_data[30:0];
                    default:          section_mode_reg <= section_mode_reg;
                endcase
            end

            case (state_reg)
                IDLE:
                begin
                    if (start)
                    begin
                        op_reg  <= cmd.op;
                        x_reg   <= (cmd.op == OP_LOAD) ? cmd.knot_x : cmd.cut_x;
                        s_reg   <= (cmd.op == OP_LOAD) ? cmd.knot_sigma : cmd.cut_sigma;
                        idx_reg <= cmd.cut_index;
                        case (cmd.op)
                            OP_CLEAR:
                            begin
                                count_reg  <= '0;
                                done_reg   <= 1'b1;
                                result_reg <= '{ST_OK, 64'sd0, 64'sd0};
                            end
                            OP_LOAD:
                            begin
                                if (count_reg >= CW'(MAX_KNOTS))
                                begin
                                    done_reg   <= 1'b1;
                                    result_reg <= '{ST_FULL, 64'sd0, 64'sd0};
                                end
                                else if (count_reg == '0)
                                begin
                                    state_reg <= LD_W;
                                end
                                else
                                begin
                                    rd_addr_reg <= AW'(count_reg - CW'(1));
                                    ret_reg     <= LD_PREV;
                                    state_reg   <= RD_WAIT;
                                end
                            end
                            OP_QUERY:
                            begin
                                if (count_reg < CW'(2))
                                begin
                                    done_reg   <= 1'b1;
                                    result_reg <= '{ST_OK, 64'sd0, 64'sd0};
                                end
                                else
                                begin
                                    rd_addr_reg <= '0;
                                    ret_reg     <= Q_FIRST;
                                    state_reg   <= RD_WAIT;
                                end
                            end
                            default:
                            begin
                                done_reg   <= 1'b1;
                                result_reg <= '{ST_OK, 64'sd0, 64'sd0};
                            end
                        endcase
                    end
                end

                RD_WAIT:
                begin
                    state_reg <= ret_reg;
                end

                MUL_WAIT:
                begin
                    if (mul_done)
                    begin
                        prod_reg  <= mul_p;
                        state_reg <= ret_reg;
                    end
                end

                DIV_WAIT:
                begin
                    if (div_done)
                    begin
                        prod_reg  <= div_q;
                        state_reg <= ret_reg;
                    end
                end

                LD_PREV:
                begin
                    a_reg  <= rd_data.pos;
                    sa_reg <= rd_data.sig;
                    wa_reg <= rd_data.wid;
                    ap_reg <= rd_data.area;
                    mp_reg <= rd_data.moment;
                    if ($signed(x_reg) <= $signed(rd_data.pos))
                    begin
                        done_reg   <= 1'b1;
                        result_reg <= '{ST_NOT_INC, 64'sd0, 64'sd0};
                        state_reg  <= IDLE;
                    end
                    else
                    begin
                        state_reg <= LD_W;
                    end
                end

                LD_W:
                begin
                    mul_a_reg  <= sx32(width_slope_reg);
                    mul_b_reg  <= xw;
                    mul_go_reg <= 1'b1;
                    ret_reg    <= LD_W2;
                    state_reg  <= MUL_WAIT;
                end

                LD_W2:
                begin
                    w_reg <= w_new;
                    if (count_reg == '0)
                    begin
                        wr_en_reg   <= 1'b1;
                        wr_addr_reg <= '0;
                        wr_data_reg <= '{x_reg, s_reg, w_new, 64'sd0, 64'sd0};
                        count_reg   <= count_reg + CW'(1);
                        done_reg    <= 1'b1;
                        result_reg  <= '{ST_OK, 64'sd0, 64'sd0};
                        state_reg   <= IDLE;
                    end
                    else if (section_mode_reg)
                    begin
                        mul_a_reg  <= saw + sw;
                        mul_b_reg  <= waw + sx32(w_new);
                        mul_go_reg <= 1'b1;
                        ret_reg    <= LD_T1;
                        state_reg  <= MUL_WAIT;
                    end
                    else
                    begin
                        mul_a_reg  <= saw + sw;
                        mul_b_reg  <= xw - aw_w;
                        mul_go_reg <= 1'b1;
                        ret_reg    <= SEG_R;
                        state_reg  <= MUL_WAIT;
                    end
                end

                LD_T1:
                begin
                    mul_a_reg  <= prod_reg;
                    mul_b_reg  <= wide_t'({1'b0, slice_height_reg});
                    mul_go_reg <= 1'b1;
                    ret_reg    <= LD_T2;
                    state_reg  <= MUL_WAIT;
                end

                LD_T2:
                begin
                    area_reg  <= sat64(sx64(ap_reg) + trap_seg);
                    state_reg <= MOM0;
                end

                SEG_R:
                begin
                    area_reg  <= sat64(sx64(ap_reg) + rect_seg);
                    state_reg <= MOM0;
                end

                MOM0:
                begin
                    mul_a_reg  <= aw_w;
                    mul_b_reg  <= (saw <<< 1) + sw;
                    mul_go_reg <= 1'b1;
                    ret_reg    <= MOM1;
                    state_reg  <= MUL_WAIT;
                end

                MOM1:
                begin
                    acc_reg    <= prod_reg;
                    mul_a_reg  <= xw;
                    mul_b_reg  <= saw + (sw <<< 1);
                    mul_go_reg <= 1'b1;
                    ret_reg    <= MOM2;
                    state_reg  <= MUL_WAIT;
                end

                MOM2:
                begin
                    mul_a_reg  <= acc_reg + prod_reg;
                    mul_b_reg  <= xw - aw_w;
                    mul_go_reg <= 1'b1;
                    ret_reg    <= MOM3;
                    state_reg  <= MUL_WAIT;
                end

                MOM3:
                begin
                    acc_reg   <= prod_reg >>> (FRAC_BITS + 1);
                    state_reg <= MOM_R;
                end

                MOM_R:
                begin
                    rem3_reg  <= mod3(acc_reg);
                    state_reg <= MOM_Q;
                end

                MOM_Q:
                begin
                    mul_a_reg  <= acc_reg - wide_t'(rem3_reg);
                    mul_b_reg  <= INV3;
                    mul_go_reg <= 1'b1;
                    ret_reg    <= MOM4;
                    state_reg  <= MUL_WAIT;
                end

                MOM4:
                begin
                    if (op_reg == OP_LOAD)
                    begin
                        wr_en_reg   <= 1'b1;
                        wr_addr_reg <= AW'(count_reg);
                        wr_data_reg <= '{x_reg, s_reg, w_reg, area_reg, mom_new};
                        count_reg   <= count_reg + CW'(1);
                        result_reg  <= '{ST_OK, 64'sd0, 64'sd0};
                    end
                    else
                    begin
                        result_reg <= '{ST_OK, area_reg, mom_new};
                    end
                    done_reg  <= 1'b1;
                    state_reg <= IDLE;
                end

                Q_FIRST:
                begin
                    x0_reg      <= rd_data.pos;
                    rd_addr_reg <= AW'(count_reg - CW'(1));
                    ret_reg     <= Q_LAST;
                    state_reg   <= RD_WAIT;
                end

                Q_LAST:
                begin
                    if (($signed(x_reg) < $signed(x0_reg)) ||
                        ($signed(x_reg) > $signed(rd_data.pos)))
                    begin
                        done_reg   <= 1'b1;
                        result_reg <= '{ST_RANGE, 64'sd0, 64'sd0};
                        state_reg  <= IDLE;
                    end
                    else if (x_reg == x0_reg)
                    begin
                        done_reg   <= 1'b1;
                        result_reg <= '{ST_OK, 64'sd0, 64'sd0};
                        state_reg  <= IDLE;
                    end
                    else if (idx_ext >= cnt_ext)
                    begin
                        done_reg   <= 1'b1;
                        result_reg <= '{ST_BAD_INDEX, 64'sd0, 64'sd0};
                        state_reg  <= IDLE;
                    end
                    else
                    begin
                        rd_addr_reg <= AW'(idx_reg);
                        ret_reg     <= Q_IDX;
                        state_reg   <= RD_WAIT;
                    end
                end

                Q_IDX:
                begin
                    b_reg  <= rd_data.pos;
                    wb_reg <= rd_data.wid;
                    if (rd_data.pos == x_reg)
                    begin
                        done_reg   <= 1'b1;
                        result_reg <= '{ST_OK, rd_data.area,
                                        section_mode_reg ? 64'sd0 : rd_data.moment};
                        state_reg  <= IDLE;
                    end
                    else if (idx_reg == '0)
                    begin
                        done_reg   <= 1'b1;
                        result_reg <= '{ST_INDEX_ZERO, 64'sd0, 64'sd0};
                        state_reg  <= IDLE;
                    end
                    else
                    begin
                        rd_addr_reg <= AW'(idx_reg - 8'd1);
                        ret_reg     <= Q_PREV;
                        state_reg   <= RD_WAIT;
                    end
                end

                Q_PREV:
                begin
                    a_reg      <= rd_data.pos;
                    sa_reg     <= rd_data.sig;
                    wa_reg     <= rd_data.wid;
                    ap_reg     <= rd_data.area;
                    mp_reg     <= rd_data.moment;
                    mul_go_reg <= 1'b1;
                    state_reg  <= MUL_WAIT;
                    if (section_mode_reg)
                    begin
                        mul_a_reg <= wbw - sx32(rd_data.wid);
                        mul_b_reg <= xw - sx32(rd_data.pos);
                        ret_reg   <= Q_T1;
                    end
                    else
                    begin
                        mul_a_reg <= sx32(rd_data.sig) + sw;
                        mul_b_reg <= xw - sx32(rd_data.pos);
                        ret_reg   <= SEG_R;
                    end
                end

                Q_T1:
                begin
                    div_n_reg  <= prod_reg;
                    div_d_reg  <= den;
                    div_go_reg <= 1'b1;
                    ret_reg    <= Q_T2;
                    state_reg  <= DIV_WAIT;
                end

                Q_T2:
                begin
                    mul_a_reg  <= saw + sw;
                    mul_b_reg  <= waw + sx32(bb_new);
                    mul_go_reg <= 1'b1;
                    ret_reg    <= Q_T3;
                    state_reg  <= MUL_WAIT;
                end

                Q_T3:
                begin
                    mul_a_reg  <= prod_reg;
                    mul_b_reg  <= xw - aw_w;
                    mul_go_reg <= 1'b1;
                    ret_reg    <= Q_T4;
                    state_reg  <= MUL_WAIT;
                end

                Q_T4:
                begin
                    done_reg   <= 1'b1;
                    result_reg <= '{ST_OK, sat64(sx64(ap_reg) + trap_seg), 64'sd0};
                    state_reg  <= IDLE;
                end

                default:
                begin
                    state_reg <= IDLE;
                end
            endcase
        end
    end

    assign busy      = (state_reg != IDLE);
    assign done      = done_reg;
    assign result    = result_reg;
    assign cfg_ready = 1'b1;

    a_accept_progress: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (done || busy))
        else $error("accepted transaction neither finished nor in progress");

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result strobe while still busy");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(MAX_KNOTS))
        else $error("knot count beyond capacity");

    a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (result.status != ST_OK)) |-> (result.area == '0 && result.moment == '0))
        else $error("error status with nonzero integrals");

    a_unit_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        !(mul_go_reg && div_go_reg))
        else $error("multiplier and divider launched together");

endmodule

// ----- sv/plq_mem.sv -----
// ----------------------------------------------------------------------------
// plq_mem: knot memory
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module plq_mem #(
    parameter int DEPTH = 256,
    parameter int AW    = 8
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  plq_pkg::entry_t  wr_data,
    input  logic [AW-1:0]    rd_addr,
    output plq_pkg::entry_t  rd_data
);
    import plq_pkg::*;

    entry_t mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_data <= mem[rd_addr];
    end

endmodule

// ----- sv/plq_mul.sv -----
// ----------------------------------------------------------------------------
// plq_mul: iterative 128 x 128 multiplier, product modulo 2^128
// Accumulates one 32 x 32 partial product per cycle, sixteen in all.
// ----------------------------------------------------------------------------
module plq_mul (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           go,
    input  plq_pkg::wide_t a,
    input  plq_pkg::wide_t b,
    output logic           done,
    output plq_pkg::wide_t p
);
    import plq_pkg::*;

    wide_t       a_reg;
    wide_t       b_reg;
    logic [127:0] acc_reg;
    logic [3:0]  cnt_reg;
    logic        run_reg;
    logic        done_reg;

    logic [31:0]  aw;
    logic [31:0]  bw;
    logic [63:0]  pp;
    logic [2:0]   wsum;
    logic [127:0] pp_sh;

    always_comb
    begin
        aw    = a_reg[cnt_reg[3:2]*32 +: 32];
        bw    = b_reg[cnt_reg[1:0]*32 +: 32];
        pp    = aw * bw;
        wsum  = 3'(cnt_reg[3:2]) + 3'(cnt_reg[1:0]);
        pp_sh = 128'(pp) << {wsum, 5'b0};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_reg    <= '0;
            b_reg    <= '0;
            acc_reg  <= '0;
            cnt_reg  <= '0;
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (go)
            begin
                a_reg   <= a;
                b_reg   <= b;
                acc_reg <= '0;
                cnt_reg <= '0;
                run_reg <= 1'b1;
            end
            else if (run_reg)
            begin
                acc_reg <= acc_reg + pp_sh;
                cnt_reg <= cnt_reg + 4'd1;
                if (cnt_reg == 4'd15)
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done = done_reg;
    assign p    = wide_t'(acc_reg);

endmodule

// ----- sv/plq_div.sv -----
// ----------------------------------------------------------------------------
// plq_div: floor division of a signed 128-bit value by an unsigned 32-bit one
// Restoring division, one quotient bit per cycle, then a sign fix step.
// ----------------------------------------------------------------------------
module plq_div (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           go,
    input  plq_pkg::wide_t n,
    input  logic [31:0]    d,
    output logic           done,
    output plq_pkg::wide_t q
);
    import plq_pkg::*;

    typedef enum logic [1:0] {
        D_IDLE,
        D_RUN,
        D_FIX
    } dstate_t;

    dstate_t      state_reg;
    logic [127:0] sh_reg;
    logic [31:0]  rem_reg;
    logic [31:0]  d_reg;
    logic [6:0]   cnt_reg;
    logic         neg_reg;
    logic         done_reg;
    wide_t        q_reg;

    logic [32:0]  trial;
    logic         ge;
    logic [32:0]  diff;

    always_comb
    begin
        trial = {rem_reg, sh_reg[127]};
        ge    = trial >= {1'b0, d_reg};
        diff  = trial - {1'b0, d_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= D_IDLE;
            sh_reg    <= '0;
            rem_reg   <= '0;
            d_reg     <= '0;
            cnt_reg   <= '0;
            neg_reg   <= 1'b0;
            done_reg  <= 1'b0;
            q_reg     <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            case (state_reg)
                D_IDLE:
                begin
                    if (go)
                    begin
                        sh_reg    <= n[127] ? 128'(-n) : 128'(n);
                        neg_reg   <= n[127];
                        d_reg     <= d;
                        rem_reg   <= '0;
                        cnt_reg   <= '0;
                        state_reg <= D_RUN;
                    end
                end
                D_RUN:
                begin
                    rem_reg <= ge ? diff[31:0] : trial[31:0];
                    sh_reg  <= {sh_reg[126:0], ge};
                    cnt_reg <= cnt_reg + 7'd1;
                    if (cnt_reg == 7'd127)
                    begin
                        state_reg <= D_FIX;
                    end
                end
                D_FIX:
                begin
                    q_reg     <= neg_reg ? wide_t'(~sh_reg + 128'(rem_reg == '0))
                                         : wide_t'(sh_reg);
                    done_reg  <= 1'b1;
                    state_reg <= D_IDLE;
                end
                default:
                begin
                    state_reg <= D_IDLE;
                end
            endcase
        end
    end

    assign done = done_reg;
    assign q    = q_reg;

endmodule
